### sv/sda_pkg.sv
// ============================================================================
// sda_pkg: shared types and constants for the spin density accumulator
// Field widths, spin mode codes, and the controller/datapath command and
// status words.
// ============================================================================
package sda_pkg;

    localparam int IN_W    = 104;
    localparam int OUT_W   = 256;
    localparam int AMP_W   = 16;
    localparam int OCC_W   = 17;
    localparam int SQ_W    = 32;
    localparam int DEN_W   = 48;
    localparam int OP_W    = 34;
    localparam int PROD_W  = 52;
    localparam int MODE_W  = 2;

    localparam logic [MODE_W-1:0] MODE_UNPOL  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_COLL   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_NONCOL = 2'd2;

    localparam logic signed [PROD_W-1:0] DEN_MAX =
        {{(PROD_W-DEN_W+1){1'b0}}, {(DEN_W-1){1'b1}}};
    localparam logic signed [PROD_W-1:0] DEN_MIN =
        {{(PROD_W-DEN_W+1){1'b1}}, {(DEN_W-1){1'b0}}};

    typedef struct packed {
        logic load_in;
        logic do_sq;
        logic do_sum;
        logic do_mul;
        logic do_acc;
    } sda_cmd_t;

    typedef struct packed {
        logic out_full;
    } sda_status_t;

endpackage

### sv/sda_ctrl.sv
// ============================================================================
// sda_ctrl: sequencer for the spin density accumulator
// Walks each accepted word through product, sum, multiply and accumulate
// steps and holds the accumulate step while the output register is full.
// ============================================================================
module sda_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  sda_pkg::sda_status_t  status,
    output sda_pkg::sda_cmd_t     cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQ   = 3'd1;
    localparam logic [2:0] ST_SUM  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_ACC  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_tready    = (state_reg == ST_IDLE);
    assign cmd.load_in = s_tready && s_tvalid;
    assign cmd.do_sq   = (state_reg == ST_SQ);
    assign cmd.do_sum  = (state_reg == ST_SUM);
    assign cmd.do_mul  = (state_reg == ST_MUL);
    assign cmd.do_acc  = (state_reg == ST_ACC) && !status.out_full;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ:   state_next = ST_SUM;
            ST_SUM:  state_next = ST_MUL;
            ST_MUL:  state_next = ST_ACC;
            ST_ACC: begin
                if (!status.out_full) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### sv/sda_datapath.sv
// ============================================================================
// sda_datapath: arithmetic and storage of the spin density accumulator
// Amplitude products, occupation weighting, four saturating accumulators,
// the spin mode register and the output register.
// ============================================================================
module sda_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sda_pkg::sda_cmd_t             cmd,
    output sda_pkg::sda_status_t          status,
    input  logic                          cfg_valid,
    input  logic [sda_pkg::MODE_W-1:0]    cfg_data,
    input  logic [sda_pkg::IN_W-1:0]      s_tdata,
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sda_pkg::OUT_W-1:0]     m_tdata,
    output logic                          m_tlast
);

    localparam int PW = sda_pkg::PROD_W;
    localparam int DW = sda_pkg::DEN_W;

    function automatic logic signed [PW-1:0] sat_add(
        input logic signed [PW-1:0] a,
        input logic signed [PW-1:0] b
    );
        logic signed [PW-1:0] s;
        s = a + b;
        if (s > sda_pkg::DEN_MAX) begin
            return sda_pkg::DEN_MAX;
        end else if (s < sda_pkg::DEN_MIN) begin
            return sda_pkg::DEN_MIN;
        end
        return s;
    endfunction

    logic [sda_pkg::MODE_W-1:0]        mode_reg;
    logic [sda_pkg::MODE_W-1:0]        imode_reg;
    logic signed [sda_pkg::AMP_W-1:0]  ur_reg, ui_reg, dr_reg, di_reg;
    logic [sda_pkg::OCC_W-1:0]         ou_reg, od_reg, occ_b_reg;
    logic                              last_reg;

    logic signed [2*sda_pkg::AMP_W-1:0] p_uu_re_reg, p_uu_im_reg;
    logic signed [2*sda_pkg::AMP_W-1:0] p_dd_re_reg, p_dd_im_reg;
    logic signed [2*sda_pkg::AMP_W-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;

    logic [sda_pkg::SQ_W-1:0]           squ_reg, sqd_reg;
    logic [sda_pkg::SQ_W-1:0]           squ_next, sqd_next;
    logic signed [sda_pkg::OP_W-1:0]    sqa_s, sqd_s, cim_s, cre_s;
    logic signed [sda_pkg::OP_W-1:0]    op_a_reg, op_b_reg, op_c_reg, op_d_reg;
    logic signed [sda_pkg::OP_W-1:0]    op_a_next, op_b_next;
    logic [sda_pkg::OCC_W-1:0]          occ_b_next;

    logic signed [PW-1:0] ma_reg, mb_reg, mc_reg, md_reg;

    logic signed [PW-1:0] ta, tb, t2a, tc, td;
    logic signed [PW-1:0] tt, tz, ty, tx;
    logic signed [PW-1:0] nt, nz, ny, nx;
    logic signed [DW-1:0] acc_total_reg, acc_z_reg, acc_y_reg, acc_x_reg;

    logic                 m_valid_reg;
    logic                 out_last_reg;
    logic [sda_pkg::SQ_W-1:0] out_sq_up_reg, out_sq_dn_reg;
    logic [DW-1:0]        out_rho_reg, out_z_reg, out_y_reg, out_x_reg;
    logic                 noncol;

    assign noncol = (imode_reg != sda_pkg::MODE_UNPOL) && (imode_reg != sda_pkg::MODE_COLL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= sda_pkg::MODE_UNPOL;
        end else if (cfg_valid) begin
            mode_reg <= cfg_data;
        end
    end

    // capture input word
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            ur_reg    <= s_tdata[15:0];
            ui_reg    <= s_tdata[31:16];
            dr_reg    <= s_tdata[47:32];
            di_reg    <= s_tdata[63:48];
            ou_reg    <= s_tdata[80:64];
            od_reg    <= s_tdata[97:81];
            last_reg  <= s_tlast;
            imode_reg <= mode_reg;
        end
    end

    // amplitude products
    always_ff @(posedge aclk) begin
        if (cmd.do_sq) begin
            p_uu_re_reg <= ur_reg * ur_reg;
            p_uu_im_reg <= ui_reg * ui_reg;
            p_dd_re_reg <= dr_reg * dr_reg;
            p_dd_im_reg <= di_reg * di_reg;
            p_rr_reg    <= ur_reg * dr_reg;
            p_ii_reg    <= ui_reg * di_reg;
            p_ri_reg    <= ur_reg * di_reg;
            p_ir_reg    <= ui_reg * dr_reg;
        end
    end

    always_comb begin
        squ_next   = $unsigned(p_uu_re_reg) + $unsigned(p_uu_im_reg);
        sqd_next   = $unsigned(p_dd_re_reg) + $unsigned(p_dd_im_reg);
        sqa_s      = $signed({2'b00, squ_next});
        sqd_s      = $signed({2'b00, sqd_next});
        cim_s      = sda_pkg::OP_W'(p_ri_reg) - sda_pkg::OP_W'(p_ir_reg);
        cre_s      = sda_pkg::OP_W'(p_rr_reg) + sda_pkg::OP_W'(p_ii_reg);
        occ_b_next = ou_reg;
        case (imode_reg)
            sda_pkg::MODE_UNPOL: begin
                op_a_next = sqa_s;
                op_b_next = '0;
            end
            sda_pkg::MODE_COLL: begin
                op_a_next  = sqa_s;
                op_b_next  = sqd_s;
                occ_b_next = od_reg;
            end
            default: begin
                op_a_next = sqa_s + sqd_s;
                op_b_next = sqa_s - sqd_s;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.do_sum) begin
            squ_reg   <= squ_next;
            sqd_reg   <= sqd_next;
            op_a_reg  <= op_a_next;
            op_b_reg  <= op_b_next;
            op_c_reg  <= cim_s;
            op_d_reg  <= cre_s;
            occ_b_reg <= occ_b_next;
        end
    end

    // occupation weighting
    always_ff @(posedge aclk) begin
        if (cmd.do_mul) begin
            ma_reg <= $signed({1'b0, ou_reg}) * op_a_reg;
            mb_reg <= $signed({1'b0, occ_b_reg}) * op_b_reg;
            mc_reg <= $signed({1'b0, ou_reg}) * op_c_reg;
            md_reg <= $signed({1'b0, ou_reg}) * op_d_reg;
        end
    end

    always_comb begin
        ta  = ma_reg >>> 16;
        tb  = mb_reg >>> 16;
        t2a = ma_reg >>> 15;
        tc  = mc_reg >>> 15;
        td  = md_reg >>> 15;
        tt  = '0;
        tz  = '0;
        ty  = '0;
        tx  = '0;
        case (imode_reg)
            sda_pkg::MODE_UNPOL: begin
                tt = t2a;
            end
            sda_pkg::MODE_COLL: begin
                tt = ta + tb;
                tz = ta - tb;
            end
            default: begin
                tt = ta;
                tz = tb;
                ty = tc;
                tx = td;
            end
        endcase
        nt = sat_add(PW'(acc_total_reg), tt);
        nz = sat_add(PW'(acc_z_reg), tz);
        ny = sat_add(PW'(acc_y_reg), ty);
        nx = sat_add(PW'(acc_x_reg), tx);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_total_reg <= '0;
            acc_z_reg     <= '0;
            acc_y_reg     <= '0;
            acc_x_reg     <= '0;
        end else if (cmd.do_acc) begin
            if (last_reg) begin
                acc_total_reg <= '0;
                acc_z_reg     <= '0;
                acc_y_reg     <= '0;
                acc_x_reg     <= '0;
            end else begin
                acc_total_reg <= nt[DW-1:0];
                acc_z_reg     <= nz[DW-1:0];
                acc_y_reg     <= ny[DW-1:0];
                acc_x_reg     <= nx[DW-1:0];
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (cmd.do_acc) begin
            out_sq_up_reg <= squ_reg;
            out_sq_dn_reg <= (imode_reg == sda_pkg::MODE_UNPOL) ? '0 : sqd_reg;
            out_rho_reg   <= last_reg ? nt[DW-1:0] : '0;
            out_z_reg     <= (last_reg && imode_reg != sda_pkg::MODE_UNPOL) ?
                             nz[DW-1:0] : '0;
            out_y_reg     <= (last_reg && noncol) ? ny[DW-1:0] : '0;
            out_x_reg     <= (last_reg && noncol) ? nx[DW-1:0] : '0;
            out_last_reg  <= last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.do_acc) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign status.out_full = m_valid_reg && !m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {out_x_reg, out_y_reg, out_z_reg, out_rho_reg,
                       out_sq_dn_reg, out_sq_up_reg};

endmodule

### sv/spin_density_accumulator_unit.sv
// ============================================================================
// spin_density_accumulator_unit: orbital density accumulator, spin aware
// Squares orbital amplitudes and sums occupation-weighted density terms.
// ============================================================================
// Usage:
//   s_* channel takes one orbital word per quadrature point and band; s_tlast
//   marks the last band of the point. m_* channel returns one word per input
//   word with the squared magnitudes; on the word marked by m_tlast it also
//   carries the saturated density components, and the accumulators clear.
//   cfg_* channel writes spin_mode (0 unpolarized, 1 collinear,
//   2 or 3 noncollinear); write it only while no word is in flight.
//   The result is registered after the product, sum, multiply and accumulate
//   steps; the sequencer steps each word through these registers and accepts
//   no new word until the current one has left the accumulate step.
//   Reset clears the sequencer, the accumulators, spin_mode and m_tvalid.
//   A stalled receiver holds the result; the next word is still accepted and
//   waits in the accumulate step until the output register frees.
// ============================================================================
module spin_density_accumulator_unit (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [sda_pkg::MODE_W-1:0] cfg_data,    // spin_mode
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // psi_up_re[15:0] psi_up_im[31:16] psi_dn_re[47:32] psi_dn_im[63:48]
    // occ_up[80:64] occ_dn[97:81] zero[103:98]
    input  logic [sda_pkg::IN_W-1:0]   s_tdata,
    input  logic                       s_tlast,     // last_band
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // sq_up[31:0] sq_dn[63:32] rho_total[111:64] mag_z[159:112]
    // mag_y[207:160] mag_x[255:208]
    output logic [sda_pkg::OUT_W-1:0]  m_tdata,
    output logic                       m_tlast      // density_valid
);

    sda_pkg::sda_cmd_t    cmd;
    sda_pkg::sda_status_t status;

    assign cfg_ready = 1'b1;

    sda_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sda_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    a_step_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load_in, cmd.do_sq, cmd.do_sum, cmd.do_mul, cmd.do_acc}))
        else $error("more than one datapath step issued");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (cmd.do_sq && !s_tready))
        else $error("accepted word did not enter product step");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.do_acc |-> !(m_tvalid && !m_tready))
        else $error("pending result overwritten");

    a_density_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tdata[255:64] == '0))
        else $error("density fields set on a non-final word");

endmodule
